>>> sv/chacha_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the ChaCha20 stream unit.
// No dependencies; imported by every module of the unit.
package chacha_pkg;

    localparam logic [31:0] SIGMA0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HI = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_CTR = 3'd6;

    localparam logic [3:0] FULL_CHUNK = 4'd8;

    typedef logic [15:0][31:0] t_words;
    typedef logic [3:0][31:0]  t_quad;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FEED,
        ST_EMIT
    } t_state;

    function automatic t_words init_words(
        input logic [63:0] key0,
        input logic [63:0] key1,
        input logic [63:0] key2,
        input logic [63:0] key3,
        input logic [63:0] nonce_lo,
        input logic [31:0] nonce_hi,
        input logic [31:0] ctr
    );
        t_words w;
        w[0]  = SIGMA0;
        w[1]  = SIGMA1;
        w[2]  = SIGMA2;
        w[3]  = SIGMA3;
        w[4]  = key0[31:0];
        w[5]  = key0[63:32];
        w[6]  = key1[31:0];
        w[7]  = key1[63:32];
        w[8]  = key2[31:0];
        w[9]  = key2[63:32];
        w[10] = key3[31:0];
        w[11] = key3[63:32];
        w[12] = ctr;
        w[13] = nonce_lo[31:0];
        w[14] = nonce_lo[63:32];
        w[15] = nonce_hi;
        return w;
    endfunction

    function automatic logic [63:0] byte_mask(input logic [3:0] cnt);
        logic [63:0] m;
        m = '0;
        for (int j = 0; j < 8; j++) begin
            m[j*8 +: 8] = {8{(4'(j) < cnt)}};
        end
        return m;
    endfunction

endpackage

>>> sv/chacha_qr_lane.sv
`timescale 1ns / 1ps
// One quarter-round lane: computes half of a ChaCha quarter round per cycle.
// Depends on chacha_pkg for the lane word type.
module chacha_qr_lane import chacha_pkg::*; (
    input  t_quad i_q,
    input  logic  i_half,
    output t_quad o_q
);

    logic [31:0] a_n;
    logic [31:0] c_n;
    logic [31:0] d_x;
    logic [31:0] d_n;
    logic [31:0] b_x;
    logic [31:0] b_n;

    always_comb begin
        a_n = i_q[0] + i_q[1];
        d_x = i_q[3] ^ a_n;
        d_n = i_half ? {d_x[23:0], d_x[31:24]} : {d_x[15:0], d_x[31:16]};
        c_n = i_q[2] + d_n;
        b_x = i_q[1] ^ c_n;
        b_n = i_half ? {b_x[24:0], b_x[31:25]} : {b_x[19:0], b_x[31:20]};
        o_q[0] = a_n;
        o_q[1] = b_n;
        o_q[2] = c_n;
        o_q[3] = d_n;
    end

endmodule

>>> sv/chacha_merge.sv
`timescale 1ns / 1ps
// Merge stage: adds the block's input words back into the lane results.
// Depends on chacha_pkg for the state word type.
module chacha_merge import chacha_pkg::*; (
    input  t_words i_words,
    input  t_words i_init,
    output t_words o_sum
);

    always_comb begin
        for (int w = 0; w < 16; w++) begin
            o_sum[w] = i_words[w] + i_init[w];
        end
    end

endmodule

>>> sv/chacha20_stream_cipher_unit.sv
`timescale 1ns / 1ps
// ChaCha20 stream cipher unit (96-bit nonce, 32-bit block counter), top level.
// Depends on chacha_pkg, chacha_qr_lane and chacha_merge.
//
// Each transfer on the input carries up to eight message bytes and yields one
// output transfer of the bytes XORed with the keystream. A chunk that opens a
// 64-byte block first runs the rounds in the four quarter-round lanes, which
// do half a column or diagonal round per cycle, then the merge step that adds
// the input words back; the other chunks use the stored keystream block and
// go straight to the output register. One chunk is in flight at a time.
// Configuration writes are taken at any cycle; write them only while no chunk
// is in flight. Key and nonce writes apply from the next keystream block on;
// the initial counter applies from the next message.
module chacha20_stream_cipher_unit import chacha_pkg::*; #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [63:0]          i_data_in,
    input  logic [3:0]           i_byte_count,
    input  logic                 i_last_chunk,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [63:0]          o_data_out,
    output logic [3:0]           o_out_byte_count,
    output logic                 o_out_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    localparam int STEPS  = 4 * DOUBLE_ROUNDS;
    localparam int STEP_W = $clog2(STEPS);

    t_state r_state;
    t_state n_state;

    logic [63:0] r_key0;
    logic [63:0] r_key1;
    logic [63:0] r_key2;
    logic [63:0] r_key3;
    logic [63:0] r_nonce_lo;
    logic [31:0] r_nonce_hi;
    logic [31:0] r_init_ctr;

    logic              r_in_msg;
    logic [2:0]        r_pos;
    logic [31:0]       r_blk_ctr;
    logic [31:0]       r_ctr_used;
    logic [STEP_W-1:0] r_step;

    logic [63:0] r_data;
    logic [3:0]  r_cnt;
    logic        r_last;

    logic        r_out_valid;
    logic [63:0] r_out_data;
    logic [3:0]  r_out_cnt;
    logic        r_out_last;

    t_words r_words;
    t_words n_words;
    t_words load_init;
    t_words feed_init;
    t_words feed_sum;

    t_quad lane_in  [4];
    t_quad lane_out [4];

    logic        in_acc;
    logic        out_acc;
    logic        out_free;
    logic        emit_load;
    logic        round_en;
    logic        last_step;
    logic        half;
    logic        diag;
    logic [31:0] eff_ctr;
    logic [2:0]  eff_pos;
    logic        need_block;
    logic [63:0] ks;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_data_out = r_out_data;
    assign o_out_byte_count = r_out_cnt;
    assign o_out_last = r_out_last;

    assign in_acc = i_in_valid && !o_in_stall;
    assign out_acc = r_out_valid && !i_out_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign last_step = (r_step == STEP_W'(STEPS - 1));
    assign half = r_step[0];
    assign diag = r_step[1];
    assign eff_ctr = r_in_msg ? r_blk_ctr : r_init_ctr;
    assign eff_pos = r_in_msg ? r_pos : 3'd0;
    assign need_block = (eff_pos == 3'd0);
    assign ks = {r_words[{r_pos, 1'b1}], r_words[{r_pos, 1'b0}]};

    assign load_init = init_words(r_key0, r_key1, r_key2, r_key3,
                                  r_nonce_lo, r_nonce_hi, eff_ctr);
    assign feed_init = init_words(r_key0, r_key1, r_key2, r_key3,
                                  r_nonce_lo, r_nonce_hi, r_ctr_used);

    for (genvar l = 0; l < 4; l++) begin : g_lane
        for (genvar r = 0; r < 4; r++) begin : g_row
            assign lane_in[l][r] = diag ? r_words[r*4 + ((l + r) % 4)]
                                        : r_words[r*4 + l];
        end
        chacha_qr_lane u_lane (
            .i_q    (lane_in[l]),
            .i_half (half),
            .o_q    (lane_out[l])
        );
    end

    chacha_merge u_merge (
        .i_words (r_words),
        .i_init  (feed_init),
        .o_sum   (feed_sum)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = need_block ? ST_ROUND : ST_EMIT;
                end
            end
            ST_ROUND: begin
                if (last_step) begin
                    n_state = ST_FEED;
                end
            end
            ST_FEED: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        round_en = 1'b0;
        emit_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            ST_ROUND: begin
                round_en = 1'b1;
            end
            ST_FEED: begin
            end
            ST_EMIT: begin
                emit_load = out_free;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_words = r_words;
        if (in_acc && need_block) begin
            n_words = load_init;
        end else if (round_en) begin
            for (int w = 0; w < 16; w++) begin
                n_words[w] = diag ? lane_out[((w % 4) - (w / 4) + 4) % 4][w / 4]
                                  : lane_out[w % 4][w / 4];
            end
        end else if (r_state == ST_FEED) begin
            n_words = feed_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_words <= n_words;
        if (in_acc) begin
            r_data <= i_data_in;
            r_cnt <= (i_byte_count > FULL_CHUNK) ? FULL_CHUNK : i_byte_count;
            r_last <= i_last_chunk;
            if (need_block) begin
                r_ctr_used <= eff_ctr;
            end
        end
        if (emit_load) begin
            r_out_data <= (r_data ^ ks) & byte_mask(r_cnt);
            r_out_cnt <= r_cnt;
            r_out_last <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_key0 <= '0;
            r_key1 <= '0;
            r_key2 <= '0;
            r_key3 <= '0;
            r_nonce_lo <= '0;
            r_nonce_hi <= '0;
            r_init_ctr <= '0;
            r_in_msg <= 1'b0;
            r_pos <= '0;
            r_blk_ctr <= '0;
            r_step <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_KEY0:     r_key0 <= i_cfg_data;
                    CFG_KEY1:     r_key1 <= i_cfg_data;
                    CFG_KEY2:     r_key2 <= i_cfg_data;
                    CFG_KEY3:     r_key3 <= i_cfg_data;
                    CFG_NONCE_LO: r_nonce_lo <= i_cfg_data;
                    CFG_NONCE_HI: r_nonce_hi <= i_cfg_data[31:0];
                    CFG_INIT_CTR: r_init_ctr <= i_cfg_data[31:0];
                    default: begin
                    end
                endcase
            end
            if (in_acc) begin
                r_in_msg <= 1'b1;
                r_pos <= eff_pos;
                r_step <= '0;
                if (need_block) begin
                    r_blk_ctr <= eff_ctr + 32'd1;
                end
            end
            if (round_en) begin
                r_step <= r_step + STEP_W'(1);
            end
            if (emit_load) begin
                r_out_valid <= 1'b1;
                r_pos <= r_last ? 3'd0 : r_pos + 3'd1;
                r_in_msg <= !r_last;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_block_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && need_block) |=> (r_state == ST_ROUND))
        else $error("chunk at block boundary did not start the rounds");

    a_pos_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_msg |-> (r_pos == 3'd0))
        else $error("position not cleared outside a message");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_EMIT))
        else $error("result raised outside the emit state");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of chacha20_stream_cipher_unit: directed and random chunk traffic.
// Expected chunks come from a ChaCha20 keystream predictor inside this file.
// Depends on chacha_pkg (register indexes) and the unit under test.
module testbench;
    import chacha_pkg::CFG_IDX_W;
    import chacha_pkg::CFG_KEY0;
    import chacha_pkg::CFG_KEY1;
    import chacha_pkg::CFG_KEY2;
    import chacha_pkg::CFG_KEY3;
    import chacha_pkg::CFG_NONCE_LO;
    import chacha_pkg::CFG_NONCE_HI;
    import chacha_pkg::CFG_INIT_CTR;

    localparam int N_DOUBLE_ROUNDS = 10;
    localparam logic [127:0] EXPAND_32_BYTE_K =
        {32'h6b20_6574, 32'h7962_2d32, 32'h3320_646e, 32'h6170_7865};
    localparam int MAX_PRINTED = 40;

    typedef logic [15:0][31:0] t_block_words;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
        logic        last;
    } t_chunk_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [63:0]          i_data_in = '0;
    logic [3:0]           i_byte_count = '0;
    logic                 i_last_chunk = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [63:0]          o_data_out;
    logic [3:0]           o_out_byte_count;
    logic                 o_out_last;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0]          i_cfg_data = '0;

    // predictor state
    logic [63:0]   key_part [4];
    logic [63:0]   nonce_lo;
    logic [31:0]   nonce_hi;
    logic [31:0]   start_counter;
    t_block_words  keystream;
    logic [31:0]   block_counter;
    logic [2:0]    chunk_pos;
    logic          msg_open;

    t_chunk_result expected_chunks [$];

    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int chunks_sent = 0;
    int messages_sent = 0;
    int reg_writes = 0;
    int results_seen = 0;

    chacha20_stream_cipher_unit #(
        .DOUBLE_ROUNDS(N_DOUBLE_ROUNDS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_in       (i_data_in),
        .i_byte_count    (i_byte_count),
        .i_last_chunk    (i_last_chunk),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_data_out      (o_data_out),
        .o_out_byte_count(o_out_byte_count),
        .o_out_last      (o_out_last),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("chacha20_stream_cipher_unit verification failed");
        $finish;
    end

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic t_block_words mix_quarter(input t_block_words w,
                                                 input int a, input int b,
                                                 input int c, input int d);
        w[a] = w[a] + w[b]; w[d] = rotl32(w[d] ^ w[a], 16);
        w[c] = w[c] + w[d]; w[b] = rotl32(w[b] ^ w[c], 12);
        w[a] = w[a] + w[b]; w[d] = rotl32(w[d] ^ w[a], 8);
        w[c] = w[c] + w[d]; w[b] = rotl32(w[b] ^ w[c], 7);
        return w;
    endfunction

    function automatic t_block_words chacha_block(input logic [31:0] ctr);
        t_block_words seed;
        t_block_words w;
        seed[3:0] = EXPAND_32_BYTE_K;
        for (int i = 0; i < 4; i++) begin
            seed[4 + 2*i] = key_part[i][31:0];
            seed[5 + 2*i] = key_part[i][63:32];
        end
        seed[12] = ctr;
        seed[13] = nonce_lo[31:0];
        seed[14] = nonce_lo[63:32];
        seed[15] = nonce_hi;
        w = seed;
        for (int r = 0; r < N_DOUBLE_ROUNDS; r++) begin
            w = mix_quarter(w, 0, 4, 8, 12);
            w = mix_quarter(w, 1, 5, 9, 13);
            w = mix_quarter(w, 2, 6, 10, 14);
            w = mix_quarter(w, 3, 7, 11, 15);
            w = mix_quarter(w, 0, 5, 10, 15);
            w = mix_quarter(w, 1, 6, 11, 12);
            w = mix_quarter(w, 2, 7, 8, 13);
            w = mix_quarter(w, 3, 4, 9, 14);
        end
        for (int i = 0; i < 16; i++) begin
            w[i] = w[i] + seed[i];
        end
        return w;
    endfunction

    function automatic void predict_chunk(input logic [63:0] data, input logic [3:0] count,
                                          input logic last);
        t_chunk_result res;
        logic [3:0]    n;
        logic [63:0]   pad;
        logic [63:0]   mask;
        int            idx;
        n = (count > 4'd8) ? 4'd8 : count;
        if (!msg_open) begin
            block_counter = start_counter;
            chunk_pos = '0;
            msg_open = 1'b1;
        end
        if (chunk_pos == 3'd0) begin
            keystream = chacha_block(block_counter);
            block_counter = block_counter + 32'd1;
        end
        idx = 2 * int'(chunk_pos);
        pad = {keystream[idx + 1], keystream[idx]};
        mask = '0;
        for (int j = 0; j < 8; j++) begin
            if (j < int'(n)) mask[j*8 +: 8] = 8'hff;
        end
        res.data = (data ^ pad) & mask;
        res.count = n;
        res.last = last;
        expected_chunks.push_back(res);
        chunk_pos = last ? 3'd0 : chunk_pos + 3'd1;
        if (last) msg_open = 1'b0;
    endfunction

    function automatic logic [63:0] rand_data();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] MISMATCH %s: got %h want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_chunk_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_chunks.size() == 0) begin
                report_mismatch("result with none pending", o_data_out, '0);
            end else begin
                want = expected_chunks.pop_front();
                if (o_data_out !== want.data)
                    report_mismatch("data_out", o_data_out, want.data);
                if (o_out_byte_count !== want.count)
                    report_mismatch("out_byte_count", 64'(o_out_byte_count), 64'(want.count));
                if (o_out_last !== want.last)
                    report_mismatch("out_last", 64'(o_out_last), 64'(want.last));
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_stall = ($urandom_range(99) < recv_stall_pct);
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_KEY0:     key_part[0] = value;
            CFG_KEY1:     key_part[1] = value;
            CFG_KEY2:     key_part[2] = value;
            CFG_KEY3:     key_part[3] = value;
            CFG_NONCE_LO: nonce_lo = value;
            CFG_NONCE_HI: nonce_hi = value[31:0];
            CFG_INIT_CTR: start_counter = value[31:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic write_all_regs(input logic [63:0] k0, input logic [63:0] k1,
                                  input logic [63:0] k2, input logic [63:0] k3,
                                  input logic [63:0] n_lo, input logic [31:0] n_hi,
                                  input logic [31:0] ctr);
        write_reg(CFG_KEY0, k0);
        write_reg(CFG_KEY1, k1);
        write_reg(CFG_KEY2, k2);
        write_reg(CFG_KEY3, k3);
        write_reg(CFG_NONCE_LO, n_lo);
        write_reg(CFG_NONCE_HI, {32'h0, n_hi});
        write_reg(CFG_INIT_CTR, {32'h0, ctr});
    endtask

    task automatic send_chunk(input logic [63:0] data, input logic [3:0] count,
                              input logic last);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_data_in = data;
        i_byte_count = count;
        i_last_chunk = last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_chunk(data, count, last);
        chunks_sent++;
        if (last) messages_sent++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic drain_results();
        while (expected_chunks.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic test_reset_key();
        send_chunk('0, 4'd8, 1'b0);
        send_chunk('1, 4'd8, 1'b1);
        drain_results();
    endtask

    task automatic test_byte_counts();
        write_all_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom}, {$urandom, $urandom}, $urandom, 32'd7);
        send_chunk(rand_data(), 4'd0, 1'b0);
        send_chunk(rand_data(), 4'd1, 1'b0);
        send_chunk(rand_data(), 4'd7, 1'b0);
        send_chunk(rand_data(), 4'd15, 1'b0);
        send_chunk(rand_data(), 4'd9, 1'b0);
        send_chunk(rand_data(), 4'd3, 1'b1);
        drain_results();
    endtask

    task automatic test_counter_wrap();
        write_all_regs('1, '1, '1, '1, '1, 32'hffff_ffff, 32'hffff_ffff);
        for (int k = 0; k < 9; k++) begin
            send_chunk(rand_data(), 4'd8, k == 8);
        end
        drain_results();
    endtask

    task automatic test_rekey_mid_message();
        write_reg(CFG_INIT_CTR, 64'd5);
        send_chunk(rand_data(), 4'd8, 1'b0);
        send_chunk(rand_data(), 4'd8, 1'b0);
        drain_results();
        write_reg(CFG_KEY2, {$urandom, $urandom});
        write_reg(CFG_INIT_CTR, 64'd0);
        for (int k = 0; k < 7; k++) begin
            send_chunk(rand_data(), 4'd8, k == 6);
        end
        drain_results();
    endtask

    task automatic test_random_traffic(input int gap_pct, input int stall_pct,
                                       input int n_chunks);
        int          sent;
        int          len;
        logic [3:0]  cnt;
        logic [31:0] ctr;
        sent = 0;
        case ($urandom_range(2))
            0: ctr = 32'hffff_ffff - $urandom_range(3);
            1: ctr = '0;
            default: ctr = $urandom;
        endcase
        write_all_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom}, {$urandom, $urandom}, $urandom, ctr);
        send_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        while (sent < n_chunks) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
            for (int k = 0; k < len; k++) begin
                cnt = (k == len - 1) ? 4'($urandom_range(1, 8)) : 4'd8;
                if ($urandom_range(11) == 0) cnt = 4'($urandom_range(15));
                send_chunk(rand_data(), cnt, k == len - 1);
            end
            sent += len;
        end
        drain_results();
        send_gap_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        for (int i = 0; i < 4; i++) key_part[i] = '0;
        nonce_lo = '0;
        nonce_hi = '0;
        start_counter = '0;
        keystream = '0;
        block_counter = '0;
        chunk_pos = '0;
        msg_open = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_key();
        test_byte_counts();
        test_counter_wrap();
        test_rekey_mid_message();
        test_random_traffic(0, 0, 430);
        test_random_traffic(51, 0, 430);
        test_random_traffic(0, 51, 430);
        test_random_traffic(36, 36, 430);

        repeat (4 * N_DOUBLE_ROUNDS + 10) @(posedge i_clk);
        $display("Sent %0d chunks in %0d messages and checked %0d results",
                 chunks_sent, messages_sent, results_seen);
        $display("after %0d register writes; covered byte counts 0 to 15, counter wrap,",
                 reg_writes);
        $display("rekey mid-message and stall mixes.");
        if (mismatch_count == 0) begin
            $display("chacha20_stream_cipher_unit verification clean");
        end else begin
            $display("chacha20_stream_cipher_unit verification failed");
        end
        $finish;
    end
endmodule

>>> chacha20_stream_cipher_unit.f
sv/chacha_pkg.sv
sv/chacha_qr_lane.sv
sv/chacha_merge.sv
sv/chacha20_stream_cipher_unit.sv
sim/testbench.sv
